// ----- sv/zps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zps_pkg : shared types and constants of the z-buffered SSAA pixel shader
// Field widths, fixed-point constants, queue entry and status types.
// ----------------------------------------------------------------------------
package zps_pkg;

  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 256;
  localparam int SAMPLES          = 4;

  localparam int COORD_W = 12;            // 8.4 vertex coordinate
  localparam int Z_W     = 15;            // signed corner depth
  localparam int PIX_W   = 8;
  localparam int COL_W   = 8;
  localparam int DEPTH_W = 17;            // stored, clamped depth
  localparam int DIFF_W  = COORD_W + 1;   // signed coordinate difference
  localparam int EDGE_W  = 2 * DIFF_W + 2;
  localparam int AREA_W  = EDGE_W + 2;
  localparam int NUM_W   = EDGE_W + Z_W + 3;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SHADE = 1'b1
  } cmd_e;

  // what the back end has to do with one queued transaction
  typedef enum logic [1:0] {
    K_NOP   = 2'd0,   // zero result, no state change
    K_LOAD  = 2'd1,
    K_SHADE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [1:0]                 vidx;
    logic [COORD_W-1:0]         vx;
    logic [COORD_W-1:0]         vy;
    logic signed [Z_W-1:0]      vz;
    logic [3*COL_W-1:0]         color;   // {blue, green, red}
    logic [PIX_W-1:0]           px;
    logic [PIX_W-1:0]           py;
  } q_entry_t;

  typedef struct packed {
    logic                       depth_unused;
    logic signed [DEPTH_W-1:0]  depth;
    logic [3*COL_W-1:0]         color;
  } sample_raw_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0]  depth;
    logic [3*COL_W-1:0]         color;
  } sample_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ----- sv/zps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zps_in_if / zps_out_if : valid/ready channels of the pixel shader
// Command channel in, result channel out.
// ----------------------------------------------------------------------------
interface zps_in_if;
  logic                valid;
  logic                ready;
  logic                command;
  logic [1:0]          vertex_index;
  logic [11:0]         vertex_x;
  logic [11:0]         vertex_y;
  logic signed [14:0]  vertex_z;
  logic [7:0]          red;
  logic [7:0]          green;
  logic [7:0]          blue;
  logic [7:0]          pixel_x;
  logic [7:0]          pixel_y;
  modport source (output valid, command, vertex_index, vertex_x, vertex_y, vertex_z,
                  red, green, blue, pixel_x, pixel_y, input ready);
  modport sink   (input valid, command, vertex_index, vertex_x, vertex_y, vertex_z,
                  red, green, blue, pixel_x, pixel_y, output ready);
endinterface

interface zps_out_if;
  logic        valid;
  logic        ready;
  logic        written;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [3:0]  sample_mask;
  modport source (output valid, written, out_x, out_y, out_red, out_green, out_blue,
                  sample_mask, input ready);
  modport sink   (input valid, written, out_x, out_y, out_red, out_green, out_blue,
                  sample_mask, output ready);
endinterface

// ----- sv/zps_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zps_front : command front end
// Accepts transactions and classifies them into load, shade or no-op entries.
// ----------------------------------------------------------------------------
module zps_front #(
  parameter int FRAME_WIDTH  = zps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = zps_pkg::FRAME_HEIGHT_DEF
) (
  zps_in_if.sink                 in_i,
  input  zps_pkg::back_status_t  status_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output zps_pkg::q_entry_t      q_entry_o
);
  import zps_pkg::*;

  logic in_frame;

  assign in_frame = (32'(in_i.pixel_x) < FRAME_WIDTH) && (32'(in_i.pixel_y) < FRAME_HEIGHT);

  assign in_i.ready = !q_full_i && !status_i.clearing;
  assign q_push_o   = in_i.valid && in_i.ready;

  always_comb begin
    q_entry_o.vidx  = in_i.vertex_index;
    q_entry_o.vx    = in_i.vertex_x;
    q_entry_o.vy    = in_i.vertex_y;
    q_entry_o.vz    = in_i.vertex_z;
    q_entry_o.color = {in_i.blue, in_i.green, in_i.red};
    q_entry_o.px    = in_i.pixel_x;
    q_entry_o.py    = in_i.pixel_y;
    if (cmd_e'(in_i.command) == CMD_LOAD) begin
      q_entry_o.kind = (in_i.vertex_index != 2'd3) ? K_LOAD : K_NOP;
    end else begin
      q_entry_o.kind = in_frame ? K_SHADE : K_NOP;
    end
  end

endmodule

// ----- sv/zps_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zps_queue : two-entry queue between front and back end
// Lets the front keep accepting while the back end works on a pixel.
// ----------------------------------------------------------------------------
module zps_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  zps_pkg::q_entry_t  entry_i,
  output logic               full_o,
  output logic               avail_o,
  input  logic               pop_i,
  output zps_pkg::q_entry_t  head_o
);
  import zps_pkg::*;

  q_entry_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

// ----- sv/zps_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zps_back : back end, triangle store, sample memory and shading sequencer
// Edge functions, depth interpolation by a serial divider, z-test, resolve.
// ----------------------------------------------------------------------------
module zps_back #(
  parameter int FRAME_WIDTH  = zps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = zps_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_avail_i,
  input  zps_pkg::q_entry_t      q_head_i,
  output logic                   q_pop_o,
  output zps_pkg::back_status_t  status_o,
  zps_out_if.source              out_o
);
  import zps_pkg::*;

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam int ROW_W  = SAMPLES * $bits(sample_t);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_EDGE  = 9'b000001000,
    S_COV   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_WR    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // triangle store
  logic [COORD_W-1:0]        vx_q [3];
  logic [COORD_W-1:0]        vy_q [3];
  logic signed [Z_W-1:0]     vz_q [3];
  logic [3*COL_W-1:0]        tcol_q;

  // sample memory, one row of four samples per pixel
  logic [ROW_W-1:0]          row_mem [PIXELS];
  logic [ROW_W-1:0]          rd_data_q;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic [ROW_W-1:0]          mem_wdata;

  logic [ADDR_W-1:0]         clr_addr_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [PIX_W-1:0]          px_q, py_q;
  sample_t                   row_q [SAMPLES];
  logic [1:0]                k_q, j_q;
  logic [SAMPLES-1:0]        mask_q;
  logic signed [EDGE_W-1:0]  e_q [3];
  logic signed [AREA_W-1:0]  area_q;
  logic signed [NUM_W-1:0]   num_q;
  logic                      neg_q;
  logic [AREA_W-1:0]         den_q;
  logic [AREA_W:0]           rem_q;
  logic [NUM_W-1:0]          quo_q;
  logic [CNT_W-1:0]          cnt_q;

  logic                      out_vld_q;
  logic                      out_wr_q;
  logic [PIX_W-1:0]          out_x_q, out_y_q;
  logic [COL_W-1:0]          out_r_q, out_g_q, out_b_q;
  logic [SAMPLES-1:0]        out_mask_q;
  logic                      out_free;

  assign out_free = !out_vld_q || out_o.ready;

  // ---- edge of the current corner pair at the current sample point ----
  logic [COORD_W-1:0]        sx, sy;
  logic [COORD_W-1:0]        ax, ay, bx, by;
  logic signed [DIFF_W-1:0]  dxb, dyb, dxp, dyp;
  logic signed [EDGE_W-1:0]  edge_v;

  assign sx = {px_q, 4'd0} + (k_q[1] ? COORD_W'(12) : COORD_W'(4));
  assign sy = {py_q, 4'd0} + (k_q[0] ? COORD_W'(12) : COORD_W'(4));

  always_comb begin
    unique case (j_q)
      2'd0:    begin ax = vx_q[0]; ay = vy_q[0]; bx = vx_q[1]; by = vy_q[1]; end
      2'd1:    begin ax = vx_q[1]; ay = vy_q[1]; bx = vx_q[2]; by = vy_q[2]; end
      default: begin ax = vx_q[2]; ay = vy_q[2]; bx = vx_q[0]; by = vy_q[0]; end
    endcase
  end

  assign dxb    = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign dyb    = $signed({1'b0, by}) - $signed({1'b0, ay});
  assign dxp    = $signed({1'b0, sx}) - $signed({1'b0, ax});
  assign dyp    = $signed({1'b0, sy}) - $signed({1'b0, ay});
  assign edge_v = EDGE_W'(dxb * dyp) - EDGE_W'(dyb * dxp);

  // ---- depth numerator term: e1*z0, e2*z1, e0*z2 ----
  logic signed [EDGE_W-1:0]  mul_e;
  logic signed [Z_W-1:0]     mul_z;
  logic signed [NUM_W-1:0]   prod;

  always_comb begin
    unique case (j_q)
      2'd0:    begin mul_e = e_q[1]; mul_z = vz_q[0]; end
      2'd1:    begin mul_e = e_q[2]; mul_z = vz_q[1]; end
      default: begin mul_e = e_q[0]; mul_z = vz_q[2]; end
    endcase
  end

  assign prod = NUM_W'(mul_e * mul_z);

  // ---- coverage ----
  logic covered;
  assign covered = (e_q[0] > 0 && e_q[1] > 0 && e_q[2] > 0) ||
                   (e_q[0] < 0 && e_q[1] < 0 && e_q[2] < 0);

  // ---- restoring divider step ----
  logic [AREA_W:0] rem_sh;
  logic            rem_ge;
  assign rem_sh = {rem_q[AREA_W-1:0], quo_q[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // ---- clamp and z-test ----
  logic signed [DEPTH_W-1:0] z_fin;
  logic                      z_win;
  always_comb begin
    if (neg_q) begin
      z_fin = (quo_q > NUM_W'(65536)) ? DEPTH_MIN : -$signed(DEPTH_W'(quo_q));
    end else begin
      z_fin = (quo_q > NUM_W'(65535)) ? DEPTH_MAX : $signed(DEPTH_W'(quo_q));
    end
  end
  assign z_win = z_fin > row_q[k_q].depth;

  // ---- resolve ----
  logic [COL_W+1:0] sum_r, sum_g, sum_b;
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      sum_r = sum_r + (COL_W+2)'(row_q[i].color[COL_W-1:0]);
      sum_g = sum_g + (COL_W+2)'(row_q[i].color[2*COL_W-1:COL_W]);
      sum_b = sum_b + (COL_W+2)'(row_q[i].color[3*COL_W-1:2*COL_W]);
    end
  end

  // ---- memory ports ----
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      mem_wdata[i*$bits(sample_t) +: $bits(sample_t)] =
        (state_q == S_CLEAR) ? {DEPTH_MIN, {(3*COL_W){1'b0}}} : row_q[i];
    end
  end
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WR && out_free);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
  assign mem_raddr = ADDR_W'(32'(q_head_i.py) * FRAME_WIDTH + 32'(q_head_i.px));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= row_mem[mem_raddr];
  end

  assign q_pop_o           = (state_q == S_IDLE) && q_avail_i &&
                             (q_head_i.kind == K_SHADE || out_free);
  assign status_o.clearing = (state_q == S_CLEAR);

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_addr_q == ADDR_W'(PIXELS - 1)) state_d = S_IDLE;
      S_IDLE:  if (q_pop_o && q_head_i.kind == K_SHADE) state_d = S_READ;
      S_READ:  state_d = S_EDGE;
      S_EDGE:  if (j_q == 2'd2) state_d = S_COV;
      S_COV:   state_d = covered ? S_MUL : ((k_q == 2'd3) ? S_WR : S_EDGE);
      S_MUL:   if (j_q == 2'd2) state_d = S_DIV;
      S_DIV:   if (cnt_q == CNT_W'(1)) state_d = S_FIN;
      S_FIN:   state_d = (k_q == 2'd3) ? S_WR : S_EDGE;
      S_WR:    if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
        vz_q[i] <= '0;
      end
      tcol_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (out_o.valid && out_o.ready) out_vld_q <= 1'b0;
      if (q_pop_o && q_head_i.kind != K_SHADE) out_vld_q <= 1'b1;
      if (state_q == S_WR && out_free) out_vld_q <= 1'b1;
      if (q_pop_o && q_head_i.kind == K_LOAD) begin
        vx_q[q_head_i.vidx] <= q_head_i.vx;
        vy_q[q_head_i.vidx] <= q_head_i.vy;
        vz_q[q_head_i.vidx] <= q_head_i.vz;
        if (q_head_i.vidx == 2'd0) tcol_q <= q_head_i.color;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        addr_q <= mem_raddr;
        px_q   <= q_head_i.px;
        py_q   <= q_head_i.py;
        k_q    <= 2'd0;
        j_q    <= 2'd0;
        mask_q <= '0;
        if (q_pop_o && q_head_i.kind != K_SHADE) begin
          out_wr_q   <= 1'b0;
          out_x_q    <= '0;
          out_y_q    <= '0;
          out_r_q    <= '0;
          out_g_q    <= '0;
          out_b_q    <= '0;
          out_mask_q <= '0;
        end
      end
      S_READ: begin
        for (int i = 0; i < SAMPLES; i++) begin
          row_q[i] <= rd_data_q[i*$bits(sample_t) +: $bits(sample_t)];
        end
      end
      S_EDGE: begin
        e_q[j_q] <= edge_v;
        j_q      <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
      end
      S_COV: begin
        area_q <= AREA_W'(e_q[0]) + AREA_W'(e_q[1]) + AREA_W'(e_q[2]);
        num_q  <= '0;
        if (!covered) k_q <= k_q + 2'd1;
      end
      S_MUL: begin
        num_q <= num_q + prod;
        j_q   <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        if (j_q == 2'd2) begin
          neg_q <= (num_q[NUM_W-1] ^ prod[NUM_W-1] ? (num_q + prod) < 0 : num_q[NUM_W-1])
                   ^ area_q[AREA_W-1];
          quo_q <= ((num_q + prod) < 0) ? NUM_W'(-(num_q + prod)) : NUM_W'(num_q + prod);
          den_q <= area_q[AREA_W-1] ? AREA_W'(-area_q) : AREA_W'(area_q);
          rem_q <= '0;
          cnt_q <= CNT_W'(NUM_W);
        end
      end
      S_DIV: begin
        rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_q <= {quo_q[NUM_W-2:0], rem_ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      S_FIN: begin
        if (z_win) begin
          row_q[k_q].depth <= z_fin;
          row_q[k_q].color <= tcol_q;
          mask_q[k_q]      <= 1'b1;
        end
        k_q <= k_q + 2'd1;
      end
      S_WR: begin
        if (out_free) begin
          out_wr_q   <= (mask_q != '0);
          out_x_q    <= (mask_q != '0) ? px_q : '0;
          out_y_q    <= (mask_q != '0) ? py_q : '0;
          out_r_q    <= (mask_q != '0) ? sum_r[COL_W+1:2] : '0;
          out_g_q    <= (mask_q != '0) ? sum_g[COL_W+1:2] : '0;
          out_b_q    <= (mask_q != '0) ? sum_b[COL_W+1:2] : '0;
          out_mask_q <= mask_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.written     = out_wr_q;
  assign out_o.out_x       = out_x_q;
  assign out_o.out_y       = out_y_q;
  assign out_o.out_red     = out_r_q;
  assign out_o.out_green   = out_g_q;
  assign out_o.out_blue    = out_b_q;
  assign out_o.sample_mask = out_mask_q;

  a_written_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.written == (out_o.sample_mask != '0)))
    else $error("written flag disagrees with sample mask");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.clearing |-> !q_pop_o) else $error("item taken during clearing pass");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> cnt_q == '0) else $error("divider left early");

endmodule

// ----- sv/ssaa_zbuffer_pixel_shader_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssaa_zbuffer_pixel_shader_core : flat triangle shader, z-buffer, 4x SSAA
// Top level: front end, two-entry queue, back end with the sample memory.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries commands: a load writes one triangle corner (corner 0 also
//    sets the flat colour), a shade tests the four samples of one pixel.
//  - out_o returns exactly one transaction per command; loads, off-frame
//    pixels and pixels with no winning sample give an all-zero result.
//  - Loads and off-frame shades are answered when popped. A shade pops
//    the command, reads its pixel row and, per sample, sets up the edges
//    and tests coverage and, when covered, sums the depth terms, runs a
//    serial divide for depth interpolation and a depth test; at the end
//    it writes the row back.
//  - The queue lets two commands wait while a pixel is being shaded; the
//    result register lets the back end start the next command when the
//    previous result is still pending, but it waits before producing another.
//  - After reset the sample memory is swept, one pixel row of four samples a
//    cycle, over every pixel of the frame; in_i.ready stays low meanwhile.
//  - A stalled out_o holds its transaction and back-pressures through the
//    queue to in_i.ready.
// ----------------------------------------------------------------------------
module ssaa_zbuffer_pixel_shader_core #(
  parameter int FRAME_WIDTH  = zps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = zps_pkg::FRAME_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  zps_in_if.sink     in_i,
  zps_out_if.source  out_o
);
  import zps_pkg::*;

  back_status_t status;
  q_entry_t     push_entry, head;
  logic         push, pop, full, avail;

  zps_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .in_i      (in_i),
    .status_i  (status),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_entry_o (push_entry)
  );

  zps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .avail_o (avail),
    .pop_i   (pop),
    .head_o  (head)
  );

  zps_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_avail_i (avail),
    .q_head_i  (head),
    .q_pop_o   (pop),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule
